// File: rtl/core/assert_macros.svh
// Assertion macros shared by the stopwatch RTL.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, switched off while reset is held.
`define SWMM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define SWMM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/swmm_pkg.sv
// Types, command targets and digit helpers for the mm:ss stopwatch.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package swmm_pkg;

	localparam int unsigned TPS_W = 10;
	localparam int unsigned CNT_W = 6;
	localparam int unsigned NUM_SLOTS = 8;
	localparam int unsigned SLOT_W = 3;

	localparam logic [TPS_W-1:0] TPS_RESET = 10'd60;
	localparam logic [CNT_W-1:0] UNITS_PER_WRAP = 6'd60;

	localparam logic [2:0] TGT_CLEAR  = 3'd0;
	localparam logic [2:0] TGT_LED1   = 3'd1;
	localparam logic [2:0] TGT_LED3   = 3'd2;
	localparam logic [2:0] TGT_LED4   = 3'd3;
	localparam logic [2:0] TGT_DIGIT0 = 3'd4;

	// Slot positions in the per-tick command list, in emission order.
	localparam logic [SLOT_W-1:0] SLOT_BLINK3 = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_BLINK4 = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_BTN0   = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_BTN1   = 3'd3;

	typedef struct packed {
		logic reset_button;
		logic pause_button;
		logic start_button;
	} in_item_t;

	typedef struct packed {
		logic [2:0] command_target;
		logic [3:0] digit_value;
		logic       switch_on;
		logic       last_command;
	} out_item_t;

	// Everything one tick needs to produce its commands.
	typedef struct packed {
		logic [NUM_SLOTS-1:0] slots;
		logic                 blink_led3;
		logic                 btn_reset;
		logic [3:0][3:0]      digits;
	} cmd_bundle_t;

	function automatic logic [3:0] tens_of(input logic [CNT_W-1:0] v);
		logic [3:0] t;
		t = 4'd0;
		if (v >= 6'd10) t = 4'd1;
		if (v >= 6'd20) t = 4'd2;
		if (v >= 6'd30) t = 4'd3;
		if (v >= 6'd40) t = 4'd4;
		if (v >= 6'd50) t = 4'd5;
		if (v >= 6'd60) t = 4'd6;
		return t;
	endfunction

	function automatic logic [3:0] ones_of(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = v - (CNT_W'(tens_of(v)) * CNT_W'(10));
		return r[3:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/stopwatch_mm_ss_controller.sv
// The first command of a tick is offered in the cycle after the tick is accepted.
// A tick with k commands (k up to 8) emits one command per cycle while out_ready is high;
// a tick with no command loads nothing. The next tick is taken in the cycle its
// predecessor's final command leaves, set by the single command register.
// Reset (arst_n, asynchronous): state clears, rate returns to 60, no command pending.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module stopwatch_mm_ss_controller (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire swmm_pkg::in_item_t in_item,
	output logic                out_valid,
	input  wire logic           out_ready,
	output swmm_pkg::out_item_t out_item,
	input  wire logic           cfg_we,
	input  wire logic [9:0]     cfg_wdata
);
	import swmm_pkg::*;

	cmd_bundle_t bundle;
	logic        accept;
	logic        free;

	assign in_ready = free;
	assign accept   = in_valid && in_ready;

	swmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.in_item   (in_item),
		.bundle    (bundle)
	);

	swmm_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && (|bundle.slots)),
		.bundle    (bundle),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.free      (free)
	);

	`SWMM_ASSERT_NEXT(a_more_follow,
		out_valid && out_ready && !out_item.last_command, out_valid,
		"command list ended without a last marker")
	`SWMM_ASSERT_IMP(a_led_no_digit,
		out_valid && (out_item.command_target < TGT_DIGIT0), out_item.digit_value == 4'd0,
		"non-digit command carries a digit")
	`SWMM_ASSERT_IMP(a_digit_range, out_valid, out_item.digit_value <= 4'd9,
		"digit value out of decimal range")

endmodule
`default_nettype wire

// File: rtl/core/swmm_ctrl.sv
// Stopwatch state, rate register and per-tick command bundle generation.
// Depends on swmm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swmm_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [9:0]                 cfg_wdata,
	input  wire logic                       accept,
	input  wire swmm_pkg::in_item_t         in_item,
	output swmm_pkg::cmd_bundle_t           bundle
);
	import swmm_pkg::*;

	logic [TPS_W-1:0] tps_q;
	logic [TPS_W-1:0] tick_phase_q, run_phase_q;
	logic [CNT_W-1:0] seconds_q, minutes_q;
	logic             started_q, paused_q, blink_sel_q;

	logic [TPS_W-1:0] tick_phase_d, run_phase_d;
	logic [CNT_W-1:0] seconds_d, minutes_d;
	logic             started_d, paused_d, blink_sel_d;

	logic [TPS_W-1:0] rate;
	logic [TPS_W-1:0] tick_inc, run_inc;
	logic             tick_fire, run_fire, blink;

	assign rate     = (tps_q == '0) ? TPS_W'(1) : tps_q;
	assign tick_inc = tick_phase_q + TPS_W'(1);
	assign run_inc  = run_phase_q + TPS_W'(1);
	assign tick_fire = tick_inc >= rate;
	assign blink     = tick_fire && paused_q;

	always_comb begin
		tick_phase_d = tick_fire ? '0 : tick_inc;
		run_phase_d  = run_phase_q;
		seconds_d    = seconds_q;
		minutes_d    = minutes_q;
		started_d    = started_q;
		paused_d     = paused_q;
		blink_sel_d  = blink ? !blink_sel_q : blink_sel_q;
		run_fire     = 1'b0;
		bundle       = '0;

		bundle.slots[SLOT_BLINK3] = blink;
		bundle.slots[SLOT_BLINK4] = blink;
		bundle.blink_led3         = blink_sel_q;

		if (in_item.reset_button) begin
			tick_phase_d = '0;
			run_phase_d  = '0;
			seconds_d    = '0;
			minutes_d    = '0;
			started_d    = 1'b0;
			paused_d     = 1'b0;
			blink_sel_d  = 1'b1;
			bundle.btn_reset        = 1'b1;
			bundle.slots[SLOT_BTN0] = 1'b1;
			bundle.slots[SLOT_BTN1] = 1'b1;
		end else if (in_item.pause_button) begin
			if (paused_q) begin
				paused_d = 1'b0;
				bundle.slots[SLOT_BTN0] = 1'b1;
				bundle.slots[SLOT_BTN1] = 1'b1;
			end else if (started_q) begin
				paused_d    = 1'b1;
				blink_sel_d = 1'b1;
			end
		end else if (in_item.start_button) begin
			if (!started_q) begin
				started_d = 1'b1;
				paused_d  = 1'b0;
				bundle.slots[SLOT_BTN0] = 1'b1;
				bundle.slots[SLOT_BTN1] = 1'b1;
			end
		end

		// Counting sees the state left by the buttons on this same tick.
		if (started_d && !paused_d) begin
			run_fire    = run_inc >= rate;
			run_phase_d = run_fire ? '0 : run_inc;
			if (run_fire) begin
				seconds_d = seconds_q + CNT_W'(1);
				if (seconds_d >= UNITS_PER_WRAP) begin
					seconds_d = '0;
					minutes_d = minutes_q + CNT_W'(1);
				end
				if (minutes_d >= UNITS_PER_WRAP) minutes_d = '0;
			end
		end

		bundle.slots[NUM_SLOTS-1:4] = {4{run_fire}};
		bundle.digits[0] = tens_of(minutes_d);
		bundle.digits[1] = ones_of(minutes_d);
		bundle.digits[2] = tens_of(seconds_d);
		bundle.digits[3] = ones_of(seconds_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (cfg_we) begin
			tps_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_phase_q <= '0;
			run_phase_q  <= '0;
			seconds_q    <= '0;
			minutes_q    <= '0;
			started_q    <= 1'b0;
			paused_q     <= 1'b0;
			blink_sel_q  <= 1'b1;
		end else if (accept) begin
			tick_phase_q <= tick_phase_d;
			run_phase_q  <= run_phase_d;
			seconds_q    <= seconds_d;
			minutes_q    <= minutes_d;
			started_q    <= started_d;
			paused_q     <= paused_d;
			blink_sel_q  <= blink_sel_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/swmm_emit.sv
// Command serialiser: holds one tick's bundle and emits its commands in order.
// Depends on swmm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swmm_emit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire swmm_pkg::cmd_bundle_t bundle,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output swmm_pkg::out_item_t       out_item,
	output logic                      free
);
	import swmm_pkg::*;

	logic [NUM_SLOTS-1:0] pend_q;
	cmd_bundle_t          bundle_q;
	logic [NUM_SLOTS-1:0] low_bit;
	logic [SLOT_W-1:0]    idx;
	logic                 last;

	assign low_bit   = pend_q & (~pend_q + NUM_SLOTS'(1));
	assign last      = (pend_q & ~low_bit) == '0;
	assign out_valid = |pend_q;
	// The bundle register is free when empty or when its final command leaves now.
	assign free      = !out_valid || (out_ready && last);

	always_comb begin
		idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (pend_q[i]) idx = SLOT_W'(i);
		end
	end

	always_comb begin
		out_item              = '0;
		out_item.last_command = last;
		case (idx)
			SLOT_BLINK3: begin
				out_item.command_target = TGT_LED3;
				out_item.switch_on      = bundle_q.blink_led3;
			end
			SLOT_BLINK4: begin
				out_item.command_target = TGT_LED4;
				out_item.switch_on      = !bundle_q.blink_led3;
			end
			SLOT_BTN0: begin
				out_item.command_target = bundle_q.btn_reset ? TGT_CLEAR : TGT_LED3;
				out_item.switch_on      = !bundle_q.btn_reset;
			end
			SLOT_BTN1: begin
				out_item.command_target = bundle_q.btn_reset ? TGT_LED1 : TGT_LED4;
				out_item.switch_on      = 1'b1;
			end
			default: begin
				out_item.command_target = TGT_DIGIT0 + {1'b0, idx[1:0]};
				out_item.digit_value    = bundle_q.digits[idx[1:0]];
				out_item.switch_on      = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= bundle.slots;
		end else if (out_valid && out_ready) begin
			pend_q <= pend_q & ~low_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bundle_q <= bundle;
		end
	end

endmodule
`default_nettype wire

// File: dv/stopwatch_mm_ss_controller_tb.sv
// Self-checking testbench for the mm:ss stopwatch controller: frame ticks with button
// flags go in, and every display and LED command that comes out is checked in order.
// Depends on swmm_pkg and stopwatch_mm_ss_controller with swmm_ctrl, swmm_emit and assert_macros.svh.
`timescale 1ns / 1ps
module stopwatch_mm_ss_controller_tb;
	import swmm_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int MAX_REPORTS = 40;

	localparam logic [2:0] TGT_TENS_MIN = TGT_DIGIT0;
	localparam logic [2:0] TGT_ONES_MIN = TGT_DIGIT0 + 3'd1;
	localparam logic [2:0] TGT_TENS_SEC = TGT_DIGIT0 + 3'd2;
	localparam logic [2:0] TGT_ONES_SEC = TGT_DIGIT0 + 3'd3;

	localparam in_item_t TICK_IDLE  = '{reset_button: 1'b0, pause_button: 1'b0, start_button: 1'b0};
	localparam in_item_t TICK_START = '{reset_button: 1'b0, pause_button: 1'b0, start_button: 1'b1};
	localparam in_item_t TICK_PAUSE = '{reset_button: 1'b0, pause_button: 1'b1, start_button: 1'b0};
	localparam in_item_t TICK_RESET = '{reset_button: 1'b1, pause_button: 1'b0, start_button: 1'b0};
	localparam in_item_t TICK_PS    = '{reset_button: 1'b0, pause_button: 1'b1, start_button: 1'b1};
	localparam in_item_t TICK_RP    = '{reset_button: 1'b1, pause_button: 1'b1, start_button: 1'b0};
	localparam in_item_t TICK_RS    = '{reset_button: 1'b1, pause_button: 1'b0, start_button: 1'b1};
	localparam in_item_t TICK_ALL   = '{reset_button: 1'b1, pause_button: 1'b1, start_button: 1'b1};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_item = TICK_IDLE;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_item;
	logic        cfg_we = 1'b0;
	logic [9:0]  cfg_wdata = 10'd0;

	// Predicted watch state.
	logic [9:0]  rate_cfg;
	logic [9:0]  blink_ph;
	logic [9:0]  count_ph;
	logic [5:0]  secs;
	logic [5:0]  mins;
	logic        is_started;
	logic        is_paused;
	logic        led3_next;

	in_item_t    tick_queue[$];
	out_item_t   cmd_expected[$];
	out_item_t   tick_cmds[8];
	out_item_t   cmd_want;
	int          tick_n;
	int          ticks_queued = 0;
	int          ticks_taken = 0;
	int          errors = 0;
	int          cycles = 0;
	int          tx_idle = 11;
	int          rx_idle = 48;
	bit          tick_taken = 1'b0;

	stopwatch_mm_ss_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	task automatic clear_watch();
		blink_ph = 10'd0;
		count_ph = 10'd0;
		secs = 6'd0;
		mins = 6'd0;
		is_started = 1'b0;
		is_paused = 1'b0;
		led3_next = 1'b1;
	endtask

	// A rate of zero behaves as one; a phase left above a lowered rate fires at once.
	task automatic advance_phase(inout logic [9:0] ph, output bit fired);
		logic [9:0] eff;
		logic [9:0] nxt;
		eff = (rate_cfg == 10'd0) ? 10'd1 : rate_cfg;
		nxt = ph + 10'd1;
		fired = (nxt >= eff);
		ph = fired ? 10'd0 : nxt;
	endtask

	task automatic push_cmd(input logic [2:0] tgt, input logic [3:0] dig, input logic on);
		tick_cmds[tick_n] = '{command_target: tgt, digit_value: dig, switch_on: on,
			last_command: 1'b0};
		tick_n++;
	endtask

	task automatic predict_commands(input in_item_t t);
		bit blink_fire;
		bit count_fire;
		tick_n = 0;
		advance_phase(blink_ph, blink_fire);
		if (blink_fire && is_paused) begin
			push_cmd(TGT_LED3, 4'd0, led3_next);
			push_cmd(TGT_LED4, 4'd0, !led3_next);
			led3_next = !led3_next;
		end
		if (t.reset_button) begin
			clear_watch();
			push_cmd(TGT_CLEAR, 4'd0, 1'b0);
			push_cmd(TGT_LED1, 4'd0, 1'b1);
		end else if (t.pause_button) begin
			if (is_paused) begin
				is_paused = 1'b0;
				push_cmd(TGT_LED3, 4'd0, 1'b1);
				push_cmd(TGT_LED4, 4'd0, 1'b1);
			end else if (is_started) begin
				is_paused = 1'b1;
				led3_next = 1'b1;
			end
		end else if (t.start_button && !is_started) begin
			push_cmd(TGT_LED3, 4'd0, 1'b1);
			push_cmd(TGT_LED4, 4'd0, 1'b1);
			is_paused = 1'b0;
			is_started = 1'b1;
		end
		if (is_started && !is_paused) begin
			advance_phase(count_ph, count_fire);
			if (count_fire) begin
				secs = secs + 6'd1;
				if (secs >= 6'd60) begin
					secs = 6'd0;
					mins = mins + 6'd1;
				end
				// The minute wraps before the digits go out, so 59:59 is followed by 00:00.
				if (mins >= 6'd60)
					mins = 6'd0;
				push_cmd(TGT_TENS_MIN, 4'(mins / 6'd10), 1'b1);
				push_cmd(TGT_ONES_MIN, 4'(mins % 6'd10), 1'b1);
				push_cmd(TGT_TENS_SEC, 4'(secs / 6'd10), 1'b1);
				push_cmd(TGT_ONES_SEC, 4'(secs % 6'd10), 1'b1);
			end
		end
		if (tick_n > 0)
			tick_cmds[tick_n - 1].last_command = 1'b1;
		for (int i = 0; i < tick_n; i++)
			cmd_expected.push_back(tick_cmds[i]);
	endtask

	task automatic check_field(input string name, input logic [3:0] want_v,
		input logic [3:0] got_v);
		if (want_v !== got_v) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
		end
	endtask

	// Monitor: checks each command transaction, then predicts for an accepted tick.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				rate_cfg = cfg_wdata;
			if (out_valid && out_ready) begin
				if (cmd_expected.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$error("unexpected command transaction: target %0d, digit %0d",
							out_item.command_target, out_item.digit_value);
				end else begin
					cmd_want = cmd_expected.pop_front();
					check_field("command_target", 4'(cmd_want.command_target),
						4'(out_item.command_target));
					check_field("digit_value", cmd_want.digit_value, out_item.digit_value);
					check_field("switch_on", 4'(cmd_want.switch_on), 4'(out_item.switch_on));
					check_field("last_command", 4'(cmd_want.last_command),
						4'(out_item.last_command));
				end
			end
			if (in_valid && in_ready) begin
				predict_commands(in_item);
				ticks_taken++;
				tick_taken = 1'b1;
			end
		end
	end

	// Driver: offers the next queued tick, holding it until the transaction completes.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || tick_taken) begin
			tick_taken = 1'b0;
			if (tick_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
				in_valid <= 1'b1;
				in_item <= tick_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= rx_idle);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("stopwatch_mm_ss_controller_tb failed");
			$finish;
		end
	end

	function automatic in_item_t random_tick();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 58)
			return TICK_IDLE;
		if (roll < 70)
			return TICK_START;
		if (roll < 84)
			return TICK_PAUSE;
		if (roll < 90)
			return TICK_RESET;
		return in_item_t'(3'($urandom_range(0, 7)));
	endfunction

	task automatic queue_tick(input in_item_t t);
		tick_queue.push_back(t);
		ticks_queued++;
	endtask

	task automatic queue_random(input int count);
		for (int i = 0; i < count; i++)
			queue_tick(random_tick());
	endtask

	// Waits until every tick is taken and every command has arrived, then lets a tick
	// that produced nothing finish inside the block.
	task automatic settle();
		do
			@(negedge clk);
		while (ticks_taken != ticks_queued || cmd_expected.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic begin_phase(input logic [9:0] rate, input int tx, input int rx);
		settle();
		cfg_wdata <= rate;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		tx_idle = tx;
		rx_idle = rx;
	endtask

	initial begin
		rate_cfg = TPS_RESET;
		clear_watch();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Directed walk through every button case at a short rate.
		begin_phase(10'd2, 11, 48);
		queue_tick(TICK_IDLE);
		queue_tick(TICK_PAUSE);
		queue_tick(TICK_START);
		queue_tick(TICK_START);
		queue_tick(TICK_IDLE);
		queue_tick(TICK_PAUSE);
		repeat (4) queue_tick(TICK_IDLE);
		queue_tick(TICK_START);
		queue_tick(TICK_PAUSE);
		repeat (3) queue_tick(TICK_IDLE);
		queue_tick(TICK_PS);
		queue_tick(TICK_IDLE);
		queue_tick(TICK_ALL);
		queue_tick(TICK_RP);
		queue_tick(TICK_RS);
		queue_tick(TICK_RESET);
		queue_tick(TICK_START);
		queue_tick(TICK_IDLE);

		begin_phase(10'd1, 11, 48);
		queue_random(22);

		begin_phase(10'd1023, 48, 11);
		queue_tick(TICK_START);
		queue_random(20);

		// Lowering the rate leaves both phases above it.
		begin_phase(10'd3, 48, 11);
		queue_random(20);

		// A zero rate counts every tick.
		begin_phase(10'd0, 0, 0);
		queue_tick(TICK_RESET);
		queue_tick(TICK_START);
		queue_random(12);

		begin_phase(TPS_RESET, 0, 0);
		queue_random(10);

		settle();
		repeat (6) @(negedge clk);
		if (errors == 0)
			$display("stopwatch_mm_ss_controller_tb passed");
		else
			$display("stopwatch_mm_ss_controller_tb failed");
		$finish;
	end

endmodule
